FILE: sv/bafs_pkg.sv
// ----------------------------------------------------------------------------
// bafs_pkg
// Shared codes and the request word that travels down the cell chain of the
// bit map allocator.
// ----------------------------------------------------------------------------
package bafs_pkg;

  localparam int unsigned IDX_W = 8;

  localparam logic [2:0] OP_FILL       = 3'd0;
  localparam logic [2:0] OP_SET        = 3'd1;
  localparam logic [2:0] OP_CLEAR      = 3'd2;
  localparam logic [2:0] OP_TEST       = 3'd3;
  localparam logic [2:0] OP_FIND_CLEAR = 3'd4;
  localparam logic [2:0] OP_FIND_SET   = 3'd5;

  localparam logic REG_BITS_IN_USE = 1'b0;
  localparam logic REG_START_CLEAR = 1'b1;

  localparam logic [8:0] BITS_IN_USE_RST = 9'd256;
  localparam logic       START_CLEAR_RST = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [2:0]       op;
    logic [IDX_W-1:0] bit_index;
    logic             err;
    logic             flag;
    logic [IDX_W-1:0] found_index;
  } tok_t;

endpackage

FILE: sv/bafs_cell.sv
// ----------------------------------------------------------------------------
// bafs_cell
// One word of the bit map. Applies the passing request to its word and hands
// the request, with its partial result, to the next cell.
// ----------------------------------------------------------------------------
module bafs_cell
  import bafs_pkg::*;
#(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned BASE      = 0,
  parameter int unsigned LIVE_W    = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              hold_i,
  input  logic              fill_ones_i,
  input  logic [LIVE_W-1:0] live_i,
  input  tok_t              tok_i,
  output tok_t              tok_o
);

  localparam int unsigned POS_W = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] word_q, word_d;
  tok_t                 tok_q, tok_d;
  logic                 in_word;
  logic [POS_W-1:0]     off;
  logic [WORD_BITS-1:0] live_mask;
  logic [WORD_BITS-1:0] cand;
  logic                 hit;
  logic [POS_W-1:0]     pos;

  always_comb begin
    in_word = (32'(tok_i.bit_index) >= BASE) && (32'(tok_i.bit_index) < BASE + WORD_BITS);
    off     = POS_W'(32'(tok_i.bit_index) - BASE);
    for (int j = 0; j < WORD_BITS; j++) begin
      live_mask[j] = (BASE + j) < 32'(live_i);
    end
    cand = ((tok_i.op == OP_FIND_SET) ? word_q : ~word_q) & live_mask;
    hit  = |cand;
    pos  = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        pos = POS_W'(j);
      end
    end
  end

  always_comb begin
    word_d = word_q;
    tok_d  = tok_i;
    if (tok_i.valid) begin
      case (tok_i.op)
        OP_FILL: begin
          word_d = fill_ones_i ? '1 : '0;
        end
        OP_SET: begin
          if (!tok_i.err && in_word) word_d[off] = 1'b1;
        end
        OP_CLEAR: begin
          if (!tok_i.err && in_word) word_d[off] = 1'b0;
        end
        OP_TEST: begin
          if (!tok_i.err && in_word) tok_d.flag = word_q[off];
        end
        OP_FIND_CLEAR, OP_FIND_SET: begin
          if (!tok_i.flag && hit) begin
            tok_d.flag        = 1'b1;
            tok_d.found_index = IDX_W'(BASE + 32'(pos));
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      tok_q  <= '0;
    end else begin
      word_q <= word_d;
      if (!hold_i) begin
        tok_q <= tok_d;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: sv/bitmap_allocator_find_first.sv
// ----------------------------------------------------------------------------
// bitmap_allocator_find_first
// Bit map of NUM_BITS bits with fill, set, clear, test and find-first
// clear/set operations, built as a chain of one cell per stored word.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request word: op and bit_index. m_axis returns one
//   result word per request: flag, found_index and index_error, in order.
//   The APB port holds bits_in_use (offset 0) and start_clear (offset 4);
//   write them only while no request is outstanding.
//   A request walks the cell chain, one stored word per cycle, and is
//   registered in each cell and then in the output register. A new request
//   is taken only once the one before it leaves the last cell, so just one
//   request is in the chain at a time.
//   The result sits in an output register: the next request is accepted
//   while it waits. If the receiver stalls, the following result is held in
//   the last cell and no further request is taken until it moves out.
//   Reset clears the whole map, sets bits_in_use to 256 and start_clear to 1.
// ----------------------------------------------------------------------------
module bitmap_allocator_find_first
  import bafs_pkg::*;
#(
  parameter int unsigned NUM_BITS  = 256,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // op[2:0], bit_index[10:3], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // flag[0], found_index[8:1], index_error[9], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NUM_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned LIVE_W    = $clog2(NUM_BITS + 1);

  logic [8:0]        bits_in_use_q;
  logic              start_clear_q;
  logic [LIVE_W-1:0] live;
  logic              cfg_wr;
  logic              in_acc;
  logic              move;
  logic              hold;
  logic              busy_q;
  logic              m_valid_q;
  logic              m_flag_q;
  logic [IDX_W-1:0]  m_found_q;
  logic              m_err_q;
  logic [2:0]        in_op;
  logic [IDX_W-1:0]  in_idx;
  tok_t              tok_in;
  tok_t              tok [NUM_WORDS+1];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_in_use_q <= BITS_IN_USE_RST;
      start_clear_q <= START_CLEAR_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BITS_IN_USE) begin
        bits_in_use_q <= pwdata[8:0];
      end else begin
        start_clear_q <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_START_CLEAR) ? {31'b0, start_clear_q}
                                                : {23'b0, bits_in_use_q};

  always_comb begin
    if (32'(bits_in_use_q) > NUM_BITS) begin
      live = LIVE_W'(NUM_BITS);
    end else begin
      live = LIVE_W'(bits_in_use_q);
    end
  end

  assign in_op  = s_axis_tdata[2:0];
  assign in_idx = s_axis_tdata[10:3];

  assign move          = tok[NUM_WORDS].valid && (!m_valid_q || m_axis_tready);
  assign hold          = tok[NUM_WORDS].valid && !move;
  assign s_axis_tready = !busy_q || move;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    tok_in           = '0;
    tok_in.valid     = in_acc;
    tok_in.op        = in_op;
    tok_in.bit_index = in_idx;
    tok_in.err       = (in_op inside {OP_SET, OP_CLEAR, OP_TEST})
                       && (32'(in_idx) >= 32'(live));
  end

  assign tok[0] = tok_in;

  for (genvar k = 0; k < NUM_WORDS; k++) begin : g_cell
    bafs_cell #(
      .WORD_BITS (WORD_BITS),
      .BASE      (k * WORD_BITS),
      .LIVE_W    (LIVE_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .hold_i      ((k == NUM_WORDS - 1) ? hold : 1'b0),
      .fill_ones_i (!start_clear_q),
      .live_i      (live),
      .tok_i       (tok[k]),
      .tok_o       (tok[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (move) begin
        busy_q <= 1'b0;
      end
      if (move) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      m_flag_q  <= tok[NUM_WORDS].flag;
      m_found_q <= tok[NUM_WORDS].found_index;
      m_err_q   <= tok[NUM_WORDS].err;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_err_q, m_found_q, m_flag_q};

endmodule

FILE: sv/bafs_checker.sv
// ----------------------------------------------------------------------------
// bafs_checker
// Port-level checks for the bit map allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bafs_checker #(
  parameter int unsigned NUM_WORDS = 4
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[8:0] == 9'd0)
    else $error("index error with nonzero flag or index");

  a_found_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
    else $error("found index without flag");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (NUM_WORDS > 1) && s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while chain busy");

endmodule

bind bitmap_allocator_find_first bafs_checker #(
  .NUM_WORDS (NUM_WORDS)
) u_bafs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: test/bitmap_allocator_find_first_tb.sv
// ----------------------------------------------------------------------------
// bitmap_allocator_find_first_tb
// Checks the bit map allocator one request at a time. A short directed pass
// covers fill, set, clear, test and both finds, the unused opcodes, an empty
// map, a map of one bit and an oversized bits_in_use. Random phases follow
// over several register settings. Each accepted request is run through a
// local model of the map. Each result word is compared in order against the
// model. Both stream sides idle at random, and one long receiver stall lets
// the block back up.
// ----------------------------------------------------------------------------
module bitmap_allocator_find_first_tb
  import bafs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAP_BITS   = 256;
  localparam int unsigned IDLE_PCT   = 25;
  localparam int unsigned STALL_LEN  = 400;
  localparam int unsigned SETTLE     = 8;
  localparam int unsigned CYCLE_CAP  = 600000;
  localparam int unsigned MAX_REPORT = 10;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef struct packed {
    logic [2:0]       op;
    logic [IDX_W-1:0] idx;
  } request_t;

  typedef struct packed {
    logic             flag;
    logic [IDX_W-1:0] found;
    logic             err;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // op[2:0], bit_index[10:3], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // flag[0], found_index[8:1], index_error[9], zero pad
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [MAP_BITS-1:0] map_model = '0;
  logic [8:0]          cfg_bits_in_use;
  logic                cfg_start_clear;

  request_t request_q[$];
  outcome_t outcome_q[$];
  request_t cur_req = '0;
  outcome_t got_word;
  outcome_t want_word;

  logic        no_idle;
  logic        stall_arm;
  logic        stall_done;
  int unsigned stall_left;
  int unsigned cycle_count = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_settings;
  int unsigned n_mismatch;

  bitmap_allocator_find_first DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned live_count();
    return (cfg_bits_in_use > MAP_BITS) ? MAP_BITS : int'(cfg_bits_in_use);
  endfunction

  function automatic outcome_t apply_request(request_t req);
    outcome_t    res;
    int unsigned live;
    logic        want;
    res  = '0;
    live = live_count();
    case (req.op)
      OP_FILL: begin
        map_model = cfg_start_clear ? '0 : '1;
      end
      OP_SET, OP_CLEAR, OP_TEST: begin
        if (req.idx >= live) begin
          res.err = 1'b1;
        end else if (req.op == OP_SET) begin
          map_model[req.idx] = 1'b1;
        end else if (req.op == OP_CLEAR) begin
          map_model[req.idx] = 1'b0;
        end else begin
          res.flag = map_model[req.idx];
        end
      end
      OP_FIND_CLEAR, OP_FIND_SET: begin
        want = (req.op == OP_FIND_SET);
        for (int unsigned i = 0; i < live; i++) begin
          if (map_model[i] == want) begin
            res.flag  = 1'b1;
            res.found = i[IDX_W-1:0];
            break;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, outcome_t want, outcome_t got);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORT) begin
      $display("%0t %s: expected flag=%0d found=%0d err=%0d, got flag=%0d found=%0d err=%0d",
               $realtime, what, want.flag, want.found, want.err,
               got.flag, got.found, got.err);
    end
  endtask

  // Sender: one word per handshake, fed from request_q.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        outcome_q.push_back(apply_request(cur_req));
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (request_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          cur_req = request_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {5'b0, cur_req.idx, cur_req.op};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (stall_arm && !stall_done) begin
      stall_left <= STALL_LEN;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Receiver and checker.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_word.flag  = m_axis_tdata[0];
        got_word.found = m_axis_tdata[8:1];
        got_word.err   = m_axis_tdata[9];
        n_results++;
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected result", '0, got_word);
        end else begin
          want_word = outcome_q.pop_front();
          if (got_word.flag !== want_word.flag || got_word.found !== want_word.found ||
              got_word.err !== want_word.err) begin
            report_mismatch("result mismatch", want_word, got_word);
          end
        end
      end
      m_axis_tready <= (stall_left == 0) && (no_idle || $urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("bitmap_allocator_find_first_tb: done, errors");
      $finish;
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_check(logic [2:0] addr, logic [31:0] mask, logic [31:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if ((prdata & mask) !== want) begin
      n_mismatch++;
      if (n_mismatch <= MAX_REPORT) begin
        $display("%0t register readback at %0d: expected %0h, got %0h",
                 $realtime, addr, want, prdata & mask);
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(logic [8:0] bits, logic sclear);
    apb_write({REG_BITS_IN_USE, 2'b00}, {23'b0, bits});
    cfg_bits_in_use = bits;
    apb_write({REG_START_CLEAR, 2'b00}, {31'b0, sclear});
    cfg_start_clear = sclear;
    apb_check({REG_BITS_IN_USE, 2'b00}, 32'h1ff, {23'b0, bits});
    apb_check({REG_START_CLEAR, 2'b00}, 32'h1, {31'b0, sclear});
    n_settings++;
  endtask

  task automatic push_item(logic [2:0] op, logic [IDX_W-1:0] idx);
    request_t req;
    req.op  = op;
    req.idx = idx;
    request_q.push_back(req);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (request_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [2:0] random_op();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) return OP_FILL;
    if (roll < 33) return OP_SET;
    if (roll < 53) return OP_CLEAR;
    if (roll < 68) return OP_TEST;
    if (roll < 82) return OP_FIND_CLEAR;
    if (roll < 96) return OP_FIND_SET;
    return $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
  endfunction

  function automatic logic [IDX_W-1:0] random_index();
    int unsigned live;
    live = live_count();
    if (live == 0 || $urandom_range(99) < 15) return IDX_W'($urandom_range(255));
    return IDX_W'($urandom_range(live - 1));
  endfunction

  // Drain, reprogram, then queue a fill and n random words.
  task automatic run_phase(logic [8:0] bits, logic sclear, int unsigned n);
    wait_idle();
    set_config(bits, sclear);
    @(negedge clk_i);
    push_item(OP_FILL, IDX_W'($urandom_range(255)));
    for (int unsigned i = 0; i < n; i++) begin
      push_item(random_op(), random_index());
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    no_idle         <= 1'b0;
    stall_arm       <= 1'b0;
    n_settings      = 0;
    n_mismatch      = 0;
    cfg_bits_in_use = BITS_IN_USE_RST;
    cfg_start_clear = START_CLEAR_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    @(negedge clk_i);
    push_item(OP_TEST, 8'd0);
    push_item(OP_FIND_SET, 8'd0);
    push_item(OP_FIND_CLEAR, 8'd255);
    push_item(OP_SET, 8'd0);
    push_item(OP_SET, 8'd63);
    push_item(OP_SET, 8'd64);
    push_item(OP_SET, 8'd255);
    push_item(OP_TEST, 8'd255);
    push_item(OP_TEST, 8'd128);
    push_item(OP_FIND_SET, 8'd0);
    push_item(OP_CLEAR, 8'd0);
    push_item(OP_FIND_SET, 8'd0);
    push_item(OP_SPARE_A, 8'd255);
    push_item(OP_SPARE_B, 8'd0);
    push_item(OP_FILL, 8'd0);
    push_item(OP_FIND_SET, 8'd0);
    wait_idle();
    set_config(9'd256, 1'b0);
    @(negedge clk_i);
    push_item(OP_FILL, 8'd0);
    push_item(OP_FIND_CLEAR, 8'd0);
    push_item(OP_CLEAR, 8'd200);
    push_item(OP_FIND_CLEAR, 8'd0);
    wait_idle();
    set_config(9'd0, 1'b0);
    @(negedge clk_i);
    push_item(OP_SET, 8'd5);
    push_item(OP_TEST, 8'd0);
    push_item(OP_FIND_SET, 8'd0);
    wait_idle();
    set_config(9'd511, 1'b1);
    @(negedge clk_i);
    push_item(OP_TEST, 8'd255);
    push_item(OP_CLEAR, 8'd255);
    wait_idle();
    set_config(9'd1, 1'b1);
    @(negedge clk_i);
    push_item(OP_SET, 8'd1);
    push_item(OP_CLEAR, 8'd0);
    push_item(OP_FIND_CLEAR, 8'd0);

    run_phase(9'd256, 1'b1, 250);
    stall_arm <= 1'b1;
    run_phase(9'd256, 1'b0, 200);
    run_phase(9'd1, 1'b1, 100);
    run_phase(9'd8, 1'b0, 150);
    run_phase(9'd100, 1'b1, 150);
    no_idle <= 1'b1;
    run_phase(9'd255, 1'b0, 200);
    wait_idle();
    no_idle <= 1'b0;
    run_phase(9'd257, 1'b1, 150);
    run_phase(9'd0, 1'b1, 50);
    run_phase(9'd511, 1'b0, 150);
    run_phase(9'($urandom_range(1, 256)), 1'($urandom_range(1)), 150);
    run_phase(9'd64, 1'b0, 150);
    wait_idle();
    repeat (20) @(posedge clk_i);

    n_mismatch += outcome_q.size();
    $display("covered %0d requests and %0d results over %0d register settings",
             n_accepted, n_results, n_settings);
    $display("mismatches: %0d", n_mismatch);
    if (n_mismatch == 0) begin
      $display("bitmap_allocator_find_first_tb: done, clean");
    end else begin
      $display("bitmap_allocator_find_first_tb: done, errors");
    end
    $finish;
  end

endmodule
